// ===== rtl/grpid_pkg.sv =====
// Shared types, constants and helpers for the gyro rate PID axis core.
`default_nettype none

package grpid_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_RATE_OFFSET  = 3'd0;
    localparam logic [2:0] REG_INVERT_SIGN  = 3'd1;
    localparam logic [2:0] REG_GAIN_P       = 3'd2;
    localparam logic [2:0] REG_GAIN_I       = 3'd3;
    localparam logic [2:0] REG_GAIN_D       = 3'd4;
    localparam logic [2:0] REG_OUTPUT_LIMIT = 3'd5;

    // Configuration reset values
    localparam logic [15:0] RST_GAIN_P       = 16'd768;
    localparam logic [15:0] RST_GAIN_I       = 16'd5;
    localparam logic [15:0] RST_GAIN_D       = 16'd0;
    localparam logic [9:0]  RST_OUTPUT_LIMIT = 10'd400;

    // Scale and filter coefficients, as multiplier operands
    localparam logic signed [16:0] K_SCALE    = 17'sd1000;
    localparam logic signed [16:0] K_FILT_OLD = 17'sd205;
    localparam logic signed [16:0] K_FILT_NEW = 17'sd51;

    // Datapath step codes issued by the controller
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL_S   = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL_F   = 4'd3;
    localparam logic [OP_W-1:0] OP_MUL_S51 = 4'd4;
    localparam logic [OP_W-1:0] OP_FILT    = 4'd5;
    localparam logic [OP_W-1:0] OP_ERR     = 4'd6;
    localparam logic [OP_W-1:0] OP_MUL_I   = 4'd7;
    localparam logic [OP_W-1:0] OP_MUL_P   = 4'd8;
    localparam logic [OP_W-1:0] OP_MUL_D   = 4'd9;
    localparam logic [OP_W-1:0] OP_FINISH  = 4'd10;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } grpid_cmd_t;

    typedef struct packed {
        logic out_free;
    } grpid_status_t;

    localparam logic signed [43:0] S32_MAX = 44'sh0007FFFFFFF;
    localparam logic signed [43:0] S32_MIN = 44'shFFF80000000;

    // Saturate a wide intermediate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
        logic signed [43:0] r;
        begin
            if (v > S32_MAX) begin
                r = S32_MAX;
            end else if (v < S32_MIN) begin
                r = S32_MIN;
            end else begin
                r = v;
            end
            return r[31:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/grpid_ctrl.sv =====
// Step sequencer that drives the shared-multiplier datapath.
`default_nettype none

module grpid_ctrl
    import grpid_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire grpid_status_t status,
    output grpid_cmd_t         cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_MUL_S   = 4'd1;
    localparam logic [3:0] ST_MUL_F   = 4'd2;
    localparam logic [3:0] ST_MUL_S51 = 4'd3;
    localparam logic [3:0] ST_FILT    = 4'd4;
    localparam logic [3:0] ST_ERR     = 4'd5;
    localparam logic [3:0] ST_MUL_I   = 4'd6;
    localparam logic [3:0] ST_MUL_P   = 4'd7;
    localparam logic [3:0] ST_MUL_D   = 4'd8;
    localparam logic [3:0] ST_OUT     = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_MUL_S;
                end
            end
            ST_MUL_S: begin
                cmd.op     = OP_MUL_S;
                state_next = ST_MUL_F;
            end
            ST_MUL_F: begin
                cmd.op     = OP_MUL_F;
                state_next = ST_MUL_S51;
            end
            ST_MUL_S51: begin
                cmd.op     = OP_MUL_S51;
                state_next = ST_FILT;
            end
            ST_FILT: begin
                cmd.op     = OP_FILT;
                state_next = ST_ERR;
            end
            ST_ERR: begin
                cmd.op     = OP_ERR;
                state_next = ST_MUL_I;
            end
            ST_MUL_I: begin
                cmd.op     = OP_MUL_I;
                state_next = ST_MUL_P;
            end
            ST_MUL_P: begin
                cmd.op     = OP_MUL_P;
                state_next = ST_MUL_D;
            end
            ST_MUL_D: begin
                cmd.op     = OP_MUL_D;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register can take the result
                if (status.out_free) begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_MUL_S)
        else $error("accepted transfer did not start the step sequence");

    a_finish_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_FINISH |-> status.out_free)
        else $error("result written while output register occupied");

    a_wait_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT && !status.out_free |=> state_reg == ST_OUT)
        else $error("left output step without delivering result");

endmodule

`default_nettype wire

// ===== rtl/grpid_dpath.sv =====
// Datapath: configuration registers, shared multiplier, filter and PID state.
`default_nettype none

module grpid_dpath
    import grpid_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_wdata,
    input  wire logic signed [15:0]  s_raw_rate,
    input  wire logic signed [19:0]  s_target_rate,
    input  wire logic                s_clear_memory,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [10:0]       m_drive,
    output logic                     m_saturated,
    output logic signed [31:0]       m_filtered_rate,
    input  wire grpid_cmd_t          cmd,
    output grpid_status_t            status
);

    // configuration
    logic signed [15:0] offset_reg;
    logic               invert_reg;
    logic [15:0]        gain_p_reg;
    logic [15:0]        gain_i_reg;
    logic [15:0]        gain_d_reg;
    logic [9:0]         limit_reg;

    // item and work registers
    logic signed [15:0] raw_reg;
    logic signed [19:0] target_reg;
    logic               clear_reg;
    logic signed [49:0] prod_reg;
    logic signed [49:0] prod_next;
    logic signed [43:0] acc_reg;
    logic signed [43:0] acc_next;
    logic signed [19:0] s_reg;
    logic signed [31:0] e_reg;

    // persistent state
    logic signed [31:0] smooth_reg;
    logic signed [31:0] smooth_next;
    logic signed [18:0] integ_reg;
    logic signed [18:0] integ_next;
    logic signed [31:0] prev_reg;
    logic signed [31:0] prev_next;

    // output register
    logic               m_valid_reg;
    logic               m_valid_next;
    logic signed [10:0] drive_reg;
    logic               sat_reg;
    logic signed [31:0] filt_reg;

    logic signed [16:0] diff;
    logic signed [16:0] d_val;
    logic signed [32:0] de;
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] mul_p;
    logic               mul_en;
    logic signed [49:0] prod_sh;
    logic signed [43:0] ps44;
    logic signed [43:0] lim44;
    logic signed [43:0] nlim44;
    logic signed [43:0] fsum;
    logic signed [31:0] f_new;
    logic signed [31:0] e_new;
    logic signed [43:0] isum;
    logic signed [43:0] i_cl;
    logic signed [43:0] usum;
    logic signed [43:0] u_cl;
    logic               u_sat;

    assign diff  = {raw_reg[15], raw_reg} - {offset_reg[15], offset_reg};
    assign d_val = invert_reg ? -diff : diff;
    assign de    = {e_reg[31], e_reg} - {prev_reg[31], prev_reg};

    // shared multiplier operand select
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op)
            OP_MUL_S: begin
                mul_a = {{16{d_val[16]}}, d_val};
                mul_b = K_SCALE;
            end
            OP_MUL_F: begin
                mul_a = {smooth_reg[31], smooth_reg};
                mul_b = K_FILT_OLD;
            end
            OP_MUL_S51: begin
                mul_a = {{13{s_reg[19]}}, s_reg};
                mul_b = K_FILT_NEW;
            end
            OP_MUL_I: begin
                mul_a = {e_reg[31], e_reg};
                mul_b = {1'b0, gain_i_reg};
            end
            OP_MUL_P: begin
                mul_a = {e_reg[31], e_reg};
                mul_b = {1'b0, gain_p_reg};
            end
            OP_MUL_D: begin
                mul_a = de;
                mul_b = {1'b0, gain_d_reg};
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign prod_next = mul_en ? mul_p : prod_reg;

    assign prod_sh = prod_reg >>> 8;
    assign ps44    = prod_sh[43:0];
    assign lim44   = {26'd0, limit_reg, 8'd0};
    assign nlim44  = -lim44;

    assign fsum  = (acc_reg + $signed(prod_reg[43:0])) >>> 8;
    assign f_new = sat32(fsum);
    assign e_new = sat32({{12{smooth_reg[31]}}, smooth_reg}
                         - {{24{target_reg[19]}}, target_reg});

    assign isum = {{25{integ_reg[18]}}, integ_reg} + ps44;
    assign usum = acc_reg + ps44;

    always_comb begin
        if (isum > lim44) begin
            i_cl = lim44;
        end else if (isum < nlim44) begin
            i_cl = nlim44;
        end else begin
            i_cl = isum;
        end
        u_sat = 1'b1;
        if (usum > lim44) begin
            u_cl = lim44;
        end else if (usum < nlim44) begin
            u_cl = nlim44;
        end else begin
            u_cl  = usum;
            u_sat = 1'b0;
        end
    end

    // state updates per step
    always_comb begin
        acc_next    = acc_reg;
        smooth_next = smooth_reg;
        integ_next  = integ_reg;
        prev_next   = prev_reg;
        case (cmd.op)
            OP_MUL_S51: begin
                acc_next = prod_reg[43:0];
            end
            OP_FILT: begin
                smooth_next = f_new;
                // clear takes effect before this item's integrator update
                if (clear_reg) begin
                    integ_next = '0;
                    prev_next  = '0;
                end
            end
            OP_MUL_P: begin
                integ_next = i_cl[18:0];
            end
            OP_MUL_D: begin
                acc_next = {{25{integ_reg[18]}}, integ_reg} + ps44;
            end
            OP_FINISH: begin
                prev_next = e_reg;
            end
            default: begin
                acc_next = acc_reg;
            end
        endcase
    end

    assign status.out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (cmd.op == OP_FINISH) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg  <= '0;
            invert_reg  <= 1'b0;
            gain_p_reg  <= RST_GAIN_P;
            gain_i_reg  <= RST_GAIN_I;
            gain_d_reg  <= RST_GAIN_D;
            limit_reg   <= RST_OUTPUT_LIMIT;
            smooth_reg  <= '0;
            integ_reg   <= '0;
            prev_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_RATE_OFFSET:  offset_reg <= cfg_wdata;
                    REG_INVERT_SIGN:  invert_reg <= cfg_wdata[0];
                    REG_GAIN_P:       gain_p_reg <= cfg_wdata;
                    REG_GAIN_I:       gain_i_reg <= cfg_wdata;
                    REG_GAIN_D:       gain_d_reg <= cfg_wdata;
                    REG_OUTPUT_LIMIT: limit_reg  <= cfg_wdata[9:0];
                    default: begin
                        // drop writes to unknown indexes
                    end
                endcase
            end
            smooth_reg  <= smooth_next;
            integ_reg   <= integ_next;
            prev_reg    <= prev_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cmd.op == OP_LOAD) begin
            raw_reg    <= s_raw_rate;
            target_reg <= s_target_rate;
            clear_reg  <= s_clear_memory;
        end
        if (cmd.op == OP_MUL_F) begin
            s_reg <= prod_reg[26:7];
        end
        if (cmd.op == OP_ERR) begin
            e_reg <= e_new;
        end
        if (cmd.op == OP_FINISH) begin
            drive_reg <= u_cl[18:8];
            sat_reg   <= u_sat;
            filt_reg  <= smooth_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_drive         = drive_reg;
    assign m_saturated     = sat_reg;
    assign m_filtered_rate = filt_reg;

    a_finish_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_FINISH |=> m_valid)
        else $error("finished result not presented");

    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            (m_drive == $signed({1'b0, limit_reg}))
            || (m_drive == -$signed({1'b0, limit_reg})))
        else $error("saturated result not at the output limit");

    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_FILT && clear_reg |=> integ_reg == '0 && prev_reg == '0)
        else $error("clear did not zero integrator and last error");

endmodule

`default_nettype wire

// ===== rtl/gyro_rate_pid_axis_core.sv =====
// Top level: one gyro rate axis with offset, scaling, low-pass filter and PID.
//
//  Channel  Direction  Handshake                 Payload
//  s_       in         s_valid / s_ready         s_raw_rate, s_target_rate, s_clear_memory
//  m_       out        m_valid / m_ready         m_drive, m_saturated, m_filtered_rate
//  cfg_     in         cfg_wr_en (no wait)       cfg_index, cfg_wdata
//
// Each item is accepted and then runs nine steps through a single
// shared 33x17 multiplier and its product register; the last step writes its
// result to the output register.
// The next item is accepted in the cycle after the result is written, even while
// that result still waits in the output register; a stalled m_ready holds the
// next item in its last step. Reset is synchronous and active low; it restores
// register defaults and zeroes the filter, integrator and last error.
`default_nettype none

module gyro_rate_pid_axis_core
    import grpid_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic signed [15:0]  s_raw_rate,
    input  wire logic signed [19:0]  s_target_rate,
    input  wire logic                s_clear_memory,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [10:0]       m_drive,
    output logic                     m_saturated,
    output logic signed [31:0]       m_filtered_rate
);

    grpid_cmd_t    cmd;
    grpid_status_t status;

    grpid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    grpid_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_raw_rate      (s_raw_rate),
        .s_target_rate   (s_target_rate),
        .s_clear_memory  (s_clear_memory),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive         (m_drive),
        .m_saturated     (m_saturated),
        .m_filtered_rate (m_filtered_rate),
        .cmd             (cmd),
        .status          (status)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the gyro rate PID axis core: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
    import grpid_pkg::*;

    localparam int          CLK_HALF        = 4;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int          NUM_PHASES      = 12;
    localparam int          ITEMS_PER_PHASE = 100;
    localparam int          DRAIN_CYCLES    = 24;
    localparam int          MAX_REPORTS     = 40;
    localparam logic [2:0]  REG_SPARE_6     = 3'd6;
    localparam logic [2:0]  REG_SPARE_7     = 3'd7;
    localparam longint      S32_HI          = 64'sh7FFF_FFFF;
    localparam longint      S32_LO          = -64'sh8000_0000;

    typedef struct packed {
        logic signed [10:0] drive;
        logic               saturated;
        logic signed [31:0] filtered_rate;
    } axis_result_t;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e          kind;
        logic [2:0]         index;
        logic [15:0]        wdata;
        logic signed [15:0] raw_rate;
        logic signed [19:0] target_rate;
        logic               clear_memory;
        logic               typed;
        axis_result_t       want;
    } stim_row_t;

    typedef enum logic [1:0] {
        READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC
    } ready_mode_e;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_raw_rate;
    logic signed [19:0] s_target_rate;
    logic               s_clear_memory;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [10:0] m_drive;
    logic               m_saturated;
    logic signed [31:0] m_filtered_rate;

    // Hand-written expectation travels with the payload
    logic               typed_flag;
    axis_result_t       typed_want;

    // Predictor copy of the registers and the axis state
    logic signed [15:0] pr_offset = '0;
    logic               pr_invert = 1'b0;
    logic [15:0]        pr_gain_p = RST_GAIN_P;
    logic [15:0]        pr_gain_i = RST_GAIN_I;
    logic [15:0]        pr_gain_d = RST_GAIN_D;
    logic [9:0]         pr_limit  = RST_OUTPUT_LIMIT;
    int                 axis_smoothed = 0;
    int                 axis_integ    = 0;
    int                 axis_last_err = 0;

    axis_result_t       expected_q[$];
    stim_row_t          directed_rows[$];

    int                 errors          = 0;
    int                 reports         = 0;
    int                 results_checked = 0;
    int                 typed_checked   = 0;
    int                 cfg_writes      = 0;
    int                 items_sent      = 0;
    int unsigned        cycle_count     = 0;
    ready_mode_e        ready_mode      = READY_ALWAYS;
    int                 mode_left       = 0;

    gyro_rate_pid_axis_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_raw_rate      (s_raw_rate),
        .s_target_rate   (s_target_rate),
        .s_clear_memory  (s_clear_memory),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive         (m_drive),
        .m_saturated     (m_saturated),
        .m_filtered_rate (m_filtered_rate)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic longint clamp_wide(input longint v, input longint lo, input longint hi);
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            REG_RATE_OFFSET:  pr_offset = data;
            REG_INVERT_SIGN:  pr_invert = data[0];
            REG_GAIN_P:       pr_gain_p = data;
            REG_GAIN_I:       pr_gain_i = data;
            REG_GAIN_D:       pr_gain_d = data;
            REG_OUTPUT_LIMIT: pr_limit  = data[9:0];
            default: ;
        endcase
    endfunction

    // Offset, scale, filter, then the PID step with integrator and output clamps
    function automatic axis_result_t predict_axis(input logic signed [15:0] raw,
                                                  input logic signed [19:0] target,
                                                  input logic               clr);
        longint       d, s, f, e, lim, integ, u, kp, ki, kd, drv;
        axis_result_t r;
        lim = pr_limit;
        lim = lim * 256;
        kp  = pr_gain_p;
        ki  = pr_gain_i;
        kd  = pr_gain_d;
        d = raw;
        d = d - pr_offset;
        if (pr_invert) begin
            d = -d;
        end
        s = (d * 1000) >>> 7;
        f = axis_smoothed;
        f = clamp_wide((f * 205 + s * 51) >>> 8, S32_LO, S32_HI);
        axis_smoothed = int'(f);
        if (clr) begin
            axis_integ    = 0;
            axis_last_err = 0;
        end
        e = target;
        e = clamp_wide(f - e, S32_LO, S32_HI);
        integ = axis_integ;
        integ = clamp_wide(integ + ((ki * e) >>> 8), -lim, lim);
        axis_integ = int'(integ);
        u = ((kp * e) >>> 8) + integ + ((kd * (e - axis_last_err)) >>> 8);
        r.saturated = 1'b0;
        if (u > lim) begin
            u = lim;
            r.saturated = 1'b1;
        end else if (u < -lim) begin
            u = -lim;
            r.saturated = 1'b1;
        end
        axis_last_err   = int'(e);
        drv             = u >>> 8;
        r.drive         = drv[10:0];
        r.filtered_rate = f[31:0];
        return r;
    endfunction

    function automatic stim_row_t item_row(input logic signed [15:0] raw,
                                           input logic signed [19:0] target,
                                           input logic               clr);
        stim_row_t row;
        row              = '0;
        row.kind         = ROW_ITEM;
        row.raw_rate     = raw;
        row.target_rate  = target;
        row.clear_memory = clr;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic signed [15:0] raw,
                                            input logic signed [19:0] target,
                                            input logic               clr,
                                            input logic signed [10:0] drv,
                                            input logic               sat,
                                            input logic signed [31:0] filt);
        stim_row_t row;
        row                    = item_row(raw, target, clr);
        row.typed              = 1'b1;
        row.want.drive         = drv;
        row.want.saturated     = sat;
        row.want.filtered_rate = filt;
        return row;
    endfunction

    function automatic stim_row_t write_row(input logic [2:0] idx, input logic [15:0] data);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_WRITE;
        row.index = idx;
        row.wdata = data;
        return row;
    endfunction

    task automatic check_field(input string field, input longint want_v, input longint got_v);
        if (want_v != got_v) begin
            errors++;
            if (reports < MAX_REPORTS) begin
                reports++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want_v, got_v);
            end
        end
    endtask

    task automatic send_item(input stim_row_t row, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_raw_rate     <= row.raw_rate;
        s_target_rate  <= row.target_rate;
        s_clear_memory <= row.clear_memory;
        typed_flag     <= row.typed;
        typed_want     <= row.want;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_q.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // Scoreboard: registers follow config writes, results are checked in order
    always @(posedge aclk) begin
        axis_result_t want;
        if (aresetn) begin
            if (cfg_wr_en) begin
                apply_reg(cfg_index, cfg_wdata);
                cfg_writes++;
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    errors++;
                    if (reports < MAX_REPORTS) begin
                        reports++;
                        $display("%0t: result with none expected, actual drive %0d sat %0d rate %0d",
                                 $time, m_drive, m_saturated, m_filtered_rate);
                    end
                end else begin
                    want = expected_q.pop_front();
                    results_checked++;
                    check_field("drive", want.drive, m_drive);
                    check_field("saturated", want.saturated, m_saturated);
                    check_field("filtered_rate", want.filtered_rate, m_filtered_rate);
                end
            end
            if (s_valid && s_ready) begin
                want = predict_axis(s_raw_rate, s_target_rate, s_clear_memory);
                if (typed_flag) begin
                    want = typed_want;
                    typed_checked++;
                end
                expected_q.push_back(want);
            end
        end
    end

    // Receiver stalls on a pattern that is redrawn whenever its mode counter runs out
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode <= ready_mode_e'($urandom_range(0, 3));
            mode_left  <= $urandom_range(32, 256);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS: m_ready <= 1'b1;
            READY_COIN:   m_ready <= $urandom_range(0, 1);
            READY_SPARSE: m_ready <= ($urandom_range(0, 5) == 0);
            default:      m_ready <= (cycle_count[3:0] < 4'd3);
        endcase
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run stopped at cycle limit, %0d results outstanding",
                     $time, expected_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic        in_write;
        logic [2:0]  phase_idx[8];
        logic [15:0] phase_data[8];
        logic [2:0]  swap_idx;
        logic [15:0] swap_data;
        int          off_val, lim_val, raw_val, tgt_val, burst_left, gap, j;
        logic        clr;

        aresetn        <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= '0;
        cfg_wdata      <= '0;
        s_valid        <= 1'b0;
        s_raw_rate     <= '0;
        s_target_rate  <= '0;
        s_clear_memory <= 1'b0;
        typed_flag     <= 1'b0;
        typed_want     <= '0;

        // Reset state, full-scale setpoints, zero limit, ignored indexes, extreme gains
        directed_rows.push_back(typed_row(16'sd0, 20'sd0, 1'b0, 11'sd0, 1'b0, 32'sd0));
        directed_rows.push_back(typed_row(16'sd0, 20'sh7FFFF, 1'b0, -11'sd400, 1'b1, 32'sd0));
        directed_rows.push_back(typed_row(16'sd0, -20'sd524288, 1'b1, 11'sd400, 1'b1, 32'sd0));
        directed_rows.push_back(write_row(REG_OUTPUT_LIMIT, 16'hFC00));
        directed_rows.push_back(typed_row(16'sd0, 20'sd0, 1'b0, 11'sd0, 1'b0, 32'sd0));
        directed_rows.push_back(typed_row(16'sd0, 20'sd1, 1'b0, 11'sd0, 1'b1, 32'sd0));
        directed_rows.push_back(write_row(REG_SPARE_6, 16'hFFFF));
        directed_rows.push_back(write_row(REG_SPARE_7, 16'h0000));
        directed_rows.push_back(typed_row(16'sd0, -20'sd1, 1'b0, 11'sd0, 1'b1, 32'sd0));
        directed_rows.push_back(write_row(REG_OUTPUT_LIMIT, 16'h03FF));
        directed_rows.push_back(write_row(REG_GAIN_P, 16'hFFFF));
        directed_rows.push_back(write_row(REG_GAIN_I, 16'hFFFF));
        directed_rows.push_back(write_row(REG_GAIN_D, 16'hFFFF));
        directed_rows.push_back(write_row(REG_RATE_OFFSET, 16'h8000));
        directed_rows.push_back(write_row(REG_INVERT_SIGN, 16'hFFFE));
        directed_rows.push_back(item_row(16'sh7FFF, 20'sd0, 1'b0));
        directed_rows.push_back(item_row(-16'sd32768, 20'sh7FFFF, 1'b0));
        directed_rows.push_back(write_row(REG_INVERT_SIGN, 16'h0001));
        directed_rows.push_back(item_row(16'sh7FFF, -20'sd524288, 1'b1));
        directed_rows.push_back(item_row(-16'sd32768, 20'sd0, 1'b0));
        directed_rows.push_back(write_row(REG_RATE_OFFSET, 16'h7FFF));
        directed_rows.push_back(item_row(-16'sd32768, 20'sd0, 1'b1));
        directed_rows.push_back(item_row(16'sd1, -20'sd256, 1'b0));
        directed_rows.push_back(write_row(REG_GAIN_P, 16'h0000));
        directed_rows.push_back(write_row(REG_GAIN_I, 16'h0000));
        directed_rows.push_back(write_row(REG_GAIN_D, 16'h0000));
        directed_rows.push_back(item_row(16'sd1000, 20'sd100, 1'b0));
        directed_rows.push_back(item_row(-16'sd1000, -20'sd100, 1'b1));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        in_write = 1'b0;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                if (!in_write) begin
                    drain_results();
                end
                write_reg(directed_rows[i].index, directed_rows[i].wdata);
                in_write = 1'b1;
            end else begin
                if (in_write) begin
                    cfg_wr_en <= 1'b0;
                end
                in_write = 1'b0;
                send_item(directed_rows[i], $urandom_range(0, 2));
            end
        end

        burst_left = 0;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // Pick this phase's settings: defaults first, zero limit second, extremes last
            if (phase == 0) begin
                off_val = 0;
                lim_val = RST_OUTPUT_LIMIT;
                phase_data[REG_INVERT_SIGN] = 16'h0000;
                phase_data[REG_GAIN_P]      = RST_GAIN_P;
                phase_data[REG_GAIN_I]      = RST_GAIN_I;
                phase_data[REG_GAIN_D]      = RST_GAIN_D;
            end else if (phase == NUM_PHASES - 1) begin
                off_val = -32768;
                lim_val = 1023;
                phase_data[REG_INVERT_SIGN] = 16'h0001;
                phase_data[REG_GAIN_P]      = 16'hFFFF;
                phase_data[REG_GAIN_I]      = 16'hFFFF;
                phase_data[REG_GAIN_D]      = 16'hFFFF;
            end else begin
                case ($urandom_range(0, 4))
                    0:       off_val = -32768;
                    1:       off_val = 32767;
                    2:       off_val = $signed(16'($urandom));
                    default: off_val = int'($urandom_range(0, 400)) - 200;
                endcase
                case ($urandom_range(0, 5))
                    0:       lim_val = 0;
                    1:       lim_val = 1023;
                    default: lim_val = $urandom_range(1, 1023);
                endcase
                if (phase == 1) begin
                    lim_val = 0;
                end
                phase_data[REG_INVERT_SIGN] = 16'($urandom);
                for (int g = REG_GAIN_P; g <= REG_GAIN_D; g++) begin
                    case ($urandom_range(0, 9))
                        0:       phase_data[g] = 16'h0000;
                        1:       phase_data[g] = 16'hFFFF;
                        2, 3:    phase_data[g] = 16'($urandom);
                        default: phase_data[g] = 16'($urandom_range(0, 1023));
                    endcase
                end
            end
            phase_data[REG_RATE_OFFSET]  = off_val[15:0];
            phase_data[REG_OUTPUT_LIMIT] = {6'($urandom), 10'(lim_val)};
            phase_data[REG_SPARE_6]      = 16'($urandom);
            phase_data[REG_SPARE_7]      = 16'($urandom);
            for (int k = 0; k < 8; k++) begin
                phase_idx[k] = 3'(k);
            end
            // Shuffle the write order
            for (int k = 7; k > 0; k--) begin
                j            = $urandom_range(0, k);
                swap_idx     = phase_idx[k];
                phase_idx[k] = phase_idx[j];
                phase_idx[j] = swap_idx;
            end

            drain_results();
            for (int k = 0; k < 8; k++) begin
                swap_data = phase_data[phase_idx[k]];
                write_reg(phase_idx[k], swap_data);
            end
            cfg_wr_en <= 1'b0;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    gap = 0;
                end
                burst_left--;
                if ($urandom_range(0, 4) < 2) begin
                    raw_val = $signed(16'($urandom));
                end else begin
                    raw_val = off_val + int'($urandom_range(0, 4000)) - 2000;
                    raw_val = int'(clamp_wide(raw_val, -32768, 32767));
                end
                case ($urandom_range(0, 3))
                    0:       tgt_val = $signed(20'($urandom));
                    1:       tgt_val = 0;
                    default: tgt_val = int'($urandom_range(0, lim_val * 512 + 512))
                                       - (lim_val * 256 + 256);
                endcase
                clr = ($urandom_range(0, 24) == 0);
                send_item(item_row(raw_val[15:0], tgt_val[19:0], clr), gap);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        errors += expected_q.size();

        $display("Sent %0d transfers over the directed table and %0d register phases, %0d writes.",
                 items_sent, NUM_PHASES, cfg_writes);
        $display("Compared %0d results, %0d against hand-written values; %0d errors.",
                 results_checked, typed_checked, errors);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
